### hw/rtl/sql_statement_lexer_assert.svh
// Assertion macros for the lexer checker.
`ifndef SQL_STATEMENT_LEXER_ASSERT_SVH
`define SQL_STATEMENT_LEXER_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define SQLLEX_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("sql lexer check failed");

// Next-cycle implication, masked while reset is asserted.
`define SQLLEX_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("sql lexer check failed");

// Next-cycle implication that also holds across reset.
`define SQLLEX_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("sql lexer reset check failed");

`endif

### hw/rtl/sqllex_pkg.sv
// Types, codes and character helpers for the SQL statement lexer.
package sqllex_pkg;

    localparam int POS_BITS = 16;
    localparam logic [POS_BITS-1:0] MAX_LEN = {{(POS_BITS-1){1'b1}}, 1'b0};

    localparam int KW_COUNT = 21;

    // token kinds
    localparam logic [5:0] K_IDENT = 6'd0;
    localparam logic [5:0] K_INT   = 6'd1;
    localparam logic [5:0] K_STR   = 6'd2;
    localparam logic [5:0] K_KW0   = 6'd3;
    localparam logic [5:0] K_EQ    = 6'd24;
    localparam logic [5:0] K_NE    = 6'd25;
    localparam logic [5:0] K_LT    = 6'd26;
    localparam logic [5:0] K_LE    = 6'd27;
    localparam logic [5:0] K_GT    = 6'd28;
    localparam logic [5:0] K_GE    = 6'd29;
    localparam logic [5:0] K_LP    = 6'd30;
    localparam logic [5:0] K_RP    = 6'd31;
    localparam logic [5:0] K_COMMA = 6'd32;
    localparam logic [5:0] K_STAR  = 6'd33;
    localparam logic [5:0] K_SEMI  = 6'd34;
    localparam logic [5:0] K_END   = 6'd36;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_UNKNOWN = 3'd1;
    localparam logic [2:0] ERR_BANG    = 3'd2;
    localparam logic [2:0] ERR_UNTERM  = 3'd3;
    localparam logic [2:0] ERR_TOOLONG = 3'd4;

    // characters
    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_QUOTE = "'";
    localparam logic [7:0] CH_LT    = "<";
    localparam logic [7:0] CH_GT    = ">";
    localparam logic [7:0] CH_BANG  = "!";
    localparam logic [7:0] CH_EQ    = "=";
    localparam logic [7:0] CH_LP    = "(";
    localparam logic [7:0] CH_RP    = ")";
    localparam logic [7:0] CH_COMMA = ",";
    localparam logic [7:0] CH_STAR  = "*";
    localparam logic [7:0] CH_SEMI  = ";";
    localparam logic [7:0] CH_UNDER = "_";

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'd0,
        MODE_WORD  = 4'd1,
        MODE_NUM   = 4'd2,
        MODE_MINUS = 4'd3,
        MODE_STR   = 4'd4,
        MODE_STRQ  = 4'd5,
        MODE_LT    = 4'd6,
        MODE_GT    = 4'd7,
        MODE_BANG  = 4'd8
    } mode_t;

    // first member sits in the high bits, so token_kind lands at bit 0
    typedef struct packed {
        logic [7:0]  bad_byte;
        logic [2:0]  error_code;
        logic [15:0] token_len;
        logic [15:0] start_pos;
        logic [5:0]  token_kind;
    } token_res_t;

    localparam int RES_BITS   = $bits(token_res_t);
    localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic       run_last;
        token_res_t res;
    } out_ent_t;

    // keywords, right-aligned and zero-filled to the 7-byte prefix
    localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
        56'("CREATE"), 56'("TABLE"), 56'("INSERT"), 56'("INTO"), 56'("VALUES"),
        56'("SELECT"), 56'("FROM"), 56'("WHERE"), 56'("UPDATE"), 56'("SET"),
        56'("DELETE"), 56'("INT"), 56'("VARCHAR"), 56'("PRIMARY"), 56'("KEY"),
        56'("ORDER"), 56'("GROUP"), 56'("BY"), 56'("ASC"), 56'("DESC"),
        56'("COUNT")
    };

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic word_start(input logic [7:0] c);
        return is_alpha(c) || (c == CH_UNDER);
    endfunction

    function automatic logic word_part(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;
    endfunction

    // parallel compare against every keyword
    function automatic logic [5:0] word_kind(input logic [55:0] prefix,
                                             input logic too_long);
        logic [5:0] kind;
        kind = K_IDENT;
        if (!too_long) begin
            for (int i = 0; i < KW_COUNT; i++) begin
                if (prefix == KW_TEXT[i]) begin
                    kind = K_KW0 + 6'(i);
                end
            end
        end
        return kind;
    endfunction

    function automatic token_res_t make_res(input logic [5:0] kind,
                                            input logic [15:0] start,
                                            input logic [15:0] len,
                                            input logic [2:0] err,
                                            input logic [7:0] bad);
        token_res_t r;
        r.token_kind = kind;
        r.start_pos  = start;
        r.token_len  = len;
        r.error_code = err;
        r.bad_byte   = bad;
        return r;
    endfunction

endpackage

### hw/rtl/sql_statement_lexer.sv
// SQL statement lexer: byte stream in, token records out.
// A token record enters the result queue when the request that closes it is accepted.
// Throughput: one byte request per cycle while s_tready is high; a request that yields two
// records sends them one after another on the single output port, via a 4-entry result queue.
// s_tready is high while the queue has room for two records.
// Reset (aresetn low, synchronous) empties the queue and returns the lexer to idle.
module sql_statement_lexer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] byte_in
    input  logic                           s_tuser,   // [0] func (1 = end of statement)
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [5:0] token_kind, [21:6] start_pos, [37:22] token_len, [40:38] error_code,
    // [48:41] bad_byte, rest zero
    output logic [sqllex_pkg::TDATA_BITS-1:0] m_tdata,
    output logic                           m_tlast    // run_last
);
    import sqllex_pkg::*;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // lexer state
    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [55:0]         prefix_reg, prefix_next;
    logic                too_long_reg, too_long_next;
    logic                err_reg, err_next;

    // results produced by the current request
    token_res_t          res [2];
    logic [1:0]          res_cnt;
    logic [POS_BITS-1:0] p;
    logic [POS_BITS-1:0] e;
    logic                start_new;
    logic [7:0]          c;

    // result queue
    out_ent_t            q_mem [QDEPTH];
    logic [QAW-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]        count_reg;
    logic                s_accept;
    logic                m_pop;
    logic [1:0]          push_n;

    assign c        = s_tdata;
    assign s_accept = s_tvalid && s_tready;
    assign m_pop    = m_tvalid && m_tready;
    assign s_tready = (count_reg <= (QAW+1)'(QDEPTH - 2));
    assign push_n   = s_accept ? res_cnt : 2'd0;

    always_comb begin
        mode_next     = mode_reg;
        pos_next      = pos_reg;
        tstart_next   = tstart_reg;
        prefix_next   = prefix_reg;
        too_long_next = too_long_reg;
        err_next      = err_reg;
        res[0]        = '0;
        res[1]        = '0;
        res_cnt       = 2'd0;
        start_new     = 1'b0;
        p             = pos_reg + 1'b1;
        e             = pos_reg + 1'b1;

        if (s_tuser) begin
            // flush pending token, then the end record; start over
            if (!err_reg) begin
                case (mode_reg)
                    MODE_WORD: begin
                        res[0] = make_res(word_kind(prefix_reg, too_long_reg), 16'(tstart_reg),
                                          16'(e - tstart_reg), ERR_NONE, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_NUM: begin
                        res[0] = make_res(K_INT, 16'(tstart_reg), 16'(e - tstart_reg),
                                          ERR_NONE, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_MINUS: begin
                        res[0] = make_res(K_IDENT, 16'(tstart_reg), 16'd0, ERR_UNKNOWN,
                                          CH_MINUS);
                        res_cnt = 2'd1;
                    end
                    MODE_STR: begin
                        res[0] = make_res(K_IDENT, 16'(tstart_reg), 16'd0, ERR_UNTERM, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_STRQ: begin
                        res[0] = make_res(K_STR, 16'(tstart_reg), 16'(e - tstart_reg),
                                          ERR_NONE, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_LT: begin
                        res[0] = make_res(K_LT, 16'(tstart_reg), 16'd1, ERR_NONE, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_GT: begin
                        res[0] = make_res(K_GT, 16'(tstart_reg), 16'd1, ERR_NONE, 8'd0);
                        res_cnt = 2'd1;
                    end
                    MODE_BANG: begin
                        res[0] = make_res(K_IDENT, 16'(tstart_reg), 16'd0, ERR_BANG, 8'd0);
                        res_cnt = 2'd1;
                    end
                    default: begin
                    end
                endcase
            end
            res[res_cnt[0]] = make_res(K_END, 16'(e), 16'd0, ERR_NONE, 8'd0);
            res_cnt         = res_cnt + 2'd1;
            mode_next       = MODE_IDLE;
            pos_next        = '0;
            tstart_next     = '0;
            prefix_next     = '0;
            too_long_next   = 1'b0;
            err_next        = 1'b0;
        end else if (!err_reg) begin
            if (pos_reg >= MAX_LEN) begin
                res[0]    = make_res(K_IDENT, 16'd0, 16'd0, ERR_TOOLONG, 8'd0);
                res_cnt   = 2'd1;
                err_next  = 1'b1;
                mode_next = MODE_IDLE;
            end else begin
                pos_next = p;
                case (mode_reg)
                    MODE_WORD: begin
                        if (word_part(c)) begin
                            if ((p - tstart_reg) >= POS_BITS'(7)) begin
                                too_long_next = 1'b1;
                            end else begin
                                prefix_next = {prefix_reg[47:0], upcase(c)};
                            end
                        end else begin
                            res[0] = make_res(word_kind(prefix_reg, too_long_reg),
                                              16'(tstart_reg), 16'(p - tstart_reg),
                                              ERR_NONE, 8'd0);
                            res_cnt   = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_NUM: begin
                        if (!is_digit(c)) begin
                            res[0] = make_res(K_INT, 16'(tstart_reg), 16'(p - tstart_reg),
                                              ERR_NONE, 8'd0);
                            res_cnt   = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_MINUS: begin
                        if (is_digit(c)) begin
                            mode_next = MODE_NUM;
                        end else begin
                            res[0] = make_res(K_IDENT, 16'(tstart_reg), 16'd0, ERR_UNKNOWN,
                                              CH_MINUS);
                            res_cnt   = 2'd1;
                            err_next  = 1'b1;
                            mode_next = MODE_IDLE;
                        end
                    end
                    MODE_STR: begin
                        if (c == CH_QUOTE) begin
                            mode_next = MODE_STRQ;
                        end
                    end
                    MODE_STRQ: begin
                        if (c == CH_QUOTE) begin
                            mode_next = MODE_STR;   // doubled quote stays in the string
                        end else begin
                            res[0] = make_res(K_STR, 16'(tstart_reg), 16'(p - tstart_reg),
                                              ERR_NONE, 8'd0);
                            res_cnt   = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_LT: begin
                        mode_next = MODE_IDLE;
                        if (c == CH_EQ) begin
                            res[0] = make_res(K_LE, 16'(tstart_reg), 16'd2, ERR_NONE, 8'd0);
                            res_cnt = 2'd1;
                        end else if (c == CH_GT) begin
                            res[0] = make_res(K_NE, 16'(tstart_reg), 16'd2, ERR_NONE, 8'd0);
                            res_cnt = 2'd1;
                        end else begin
                            res[0] = make_res(K_LT, 16'(tstart_reg), 16'd1, ERR_NONE, 8'd0);
                            res_cnt   = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_GT: begin
                        mode_next = MODE_IDLE;
                        if (c == CH_EQ) begin
                            res[0] = make_res(K_GE, 16'(tstart_reg), 16'd2, ERR_NONE, 8'd0);
                            res_cnt = 2'd1;
                        end else begin
                            res[0] = make_res(K_GT, 16'(tstart_reg), 16'd1, ERR_NONE, 8'd0);
                            res_cnt   = 2'd1;
                            start_new = 1'b1;
                        end
                    end
                    MODE_BANG: begin
                        mode_next = MODE_IDLE;
                        if (c == CH_EQ) begin
                            res[0] = make_res(K_NE, 16'(tstart_reg), 16'd2, ERR_NONE, 8'd0);
                            res_cnt = 2'd1;
                        end else begin
                            res[0] = make_res(K_IDENT, 16'(tstart_reg), 16'd0, ERR_BANG, 8'd0);
                            res_cnt  = 2'd1;
                            err_next = 1'b1;
                        end
                    end
                    default: begin
                        start_new = 1'b1;
                    end
                endcase

                // byte that closed the previous token (or arrived idle) opens a new one
                if (start_new) begin
                    mode_next = MODE_IDLE;
                    if (!is_space(c)) begin
                        tstart_next = p;
                        if (word_start(c)) begin
                            mode_next     = MODE_WORD;
                            prefix_next   = {48'd0, upcase(c)};
                            too_long_next = 1'b0;
                        end else begin
                            case (c)
                                CH_MINUS: mode_next = MODE_MINUS;
                                CH_QUOTE: mode_next = MODE_STR;
                                CH_LT:    mode_next = MODE_LT;
                                CH_GT:    mode_next = MODE_GT;
                                CH_BANG:  mode_next = MODE_BANG;
                                CH_EQ: begin
                                    res[res_cnt[0]] = make_res(K_EQ, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                CH_LP: begin
                                    res[res_cnt[0]] = make_res(K_LP, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                CH_RP: begin
                                    res[res_cnt[0]] = make_res(K_RP, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                CH_COMMA: begin
                                    res[res_cnt[0]] = make_res(K_COMMA, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                CH_STAR: begin
                                    res[res_cnt[0]] = make_res(K_STAR, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                CH_SEMI: begin
                                    res[res_cnt[0]] = make_res(K_SEMI, 16'(p), 16'd1,
                                                               ERR_NONE, 8'd0);
                                    res_cnt = res_cnt + 2'd1;
                                end
                                default: begin
                                    if (is_digit(c)) begin
                                        mode_next = MODE_NUM;
                                    end else begin
                                        res[res_cnt[0]] = make_res(K_IDENT, 16'(p), 16'd0,
                                                                   ERR_UNKNOWN, c);
                                        res_cnt  = res_cnt + 2'd1;
                                        err_next = 1'b1;
                                    end
                                end
                            endcase
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_IDLE;
            pos_reg      <= '0;
            tstart_reg   <= '0;
            prefix_reg   <= '0;
            too_long_reg <= 1'b0;
            err_reg      <= 1'b0;
        end else if (s_accept) begin
            mode_reg     <= mode_next;
            pos_reg      <= pos_next;
            tstart_reg   <= tstart_next;
            prefix_reg   <= prefix_next;
            too_long_reg <= too_long_next;
            err_reg      <= err_next;
        end
    end

    // queue storage, no reset
    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            q_mem[wr_ptr_reg] <= '{run_last: (push_n == 2'd1), res: res[0]};
        end
        if (push_n == 2'd2) begin
            q_mem[wr_ptr_reg + 1'b1] <= '{run_last: 1'b1, res: res[1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push_n);
            if (m_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QAW+1)'(push_n) - (QAW+1)'(m_pop);
        end
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = TDATA_BITS'(q_mem[rd_ptr_reg].res);
    assign m_tlast  = q_mem[rd_ptr_reg].run_last;

endmodule

### hw/rtl/sqllex_checker.sv
// Port-level checks for the SQL statement lexer, bound to the top level.
`include "sql_statement_lexer_assert.svh"

module sqllex_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sqllex_pkg::TDATA_BITS-1:0] m_tdata,
    input logic                           m_tlast
);
    import sqllex_pkg::*;

    token_res_t r;

    assign r = token_res_t'(m_tdata[RES_BITS-1:0]);

    // a stalled output record is held
    `SQLLEX_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `SQLLEX_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))

    // end record closes every statement run and carries no error
    `SQLLEX_ASSERT_IMP(a_end_rec, m_tvalid && (r.token_kind == K_END),
        m_tlast && (r.error_code == ERR_NONE) && (r.token_len == 16'd0))

    // error records carry no kind or length; bad byte only for unknown bytes
    `SQLLEX_ASSERT_IMP(a_err_rec, m_tvalid && (r.error_code != ERR_NONE),
        (r.token_kind == K_IDENT) && (r.token_len == 16'd0) &&
        ((r.error_code == ERR_UNKNOWN) || (r.bad_byte == 8'd0)))

    // queue is empty and input ready right after reset
    `SQLLEX_ASSERT_RST(a_rst_empty, !aresetn, !m_tvalid && s_tready)

endmodule

bind sql_statement_lexer sqllex_checker u_sqllex_checker (.*);
